[rtl/oite_pkg.sv]
// Shared types, widths and the orbital step function of the index tuple enumerator.
package oite_pkg;

    localparam int NUM_ORB  = 4;
    localparam int CFG_W    = 5;
    localparam int N_W      = 4;
    localparam int ML_W     = 7;
    localparam int K_W      = 7;
    localparam int OUT_ML_W = 6;
    localparam int CAP_W    = 8;
    localparam int KP_W     = 8;
    localparam int PROD_W   = 16;
    localparam int P_W      = 10;
    localparam int IDX_W    = 2;

    typedef struct packed {
        logic [N_W-1:0]         n;
        logic signed [ML_W-1:0] ml;
        logic [K_W-1:0]         k;
    } t_orb;

    typedef struct packed {
        t_orb orb;
        logic wrap;
    } t_step;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PIDX  = 6'b000010,
        S_CANON = 6'b000100,
        S_ADV   = 6'b001000,
        S_CARRY = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    // Advance one orbital to its next (n, ml) inside the shell sequence.
    function automatic t_step orb_step(input t_orb o, input logic [CAP_W-1:0] cap);
        t_step          s;
        logic [K_W-1:0] k_up;
        s      = '{orb: o, wrap: 1'b0};
        k_up   = o.k + K_W'(1);
        if (!o.ml[ML_W-1]) begin
            if (o.n == '0) begin
                // top of the shell: open the next shell at its most negative ml
                s.orb.ml = ~o.ml;
                s.orb.k  = k_up;
                if ({1'b0, k_up} >= cap) begin
                    s.orb.ml = '0;
                    s.orb.k  = '0;
                    s.wrap   = 1'b1;
                end
            end else begin
                s.orb.n  = o.n - N_W'(1);
                s.orb.ml = o.ml + ML_W'(2);
            end
        end else if (o.ml != '1) begin
            s.orb.n  = o.n + N_W'(1);
            s.orb.ml = o.ml + ML_W'(2);
        end else begin
            s.orb.ml = o.ml + ML_W'(2);
        end
        return s;
    endfunction

endpackage

[rtl/orbital_index_tuple_enumerator_core.sv]
// Top level of the four-orbital index tuple enumerator with its step sequencer.
//
// Usage:
//   Request channel (i_valid / o_ready / i_step_request): a transaction with
//   i_step_request high emits the current tuple (n, ml of four orbitals) plus
//   the canonical and last flags, then advances the tuple. A transaction with
//   i_step_request low is absorbed and changes nothing.
//   Result channel (o_valid / i_ready): one transaction per step request,
//   held in an output register until taken.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes
//   shell_count, the highest shell of the sweep; always ready, write only
//   while idle.
//   Sequence: after acceptance the pair indices are formed in turn, sharing
//   one small multiplier, then come the canonical test, the advance of orbital
//   four and the carry steps, one per skipped candidate plus a final check
//   unless the sweep wraps; the carry chain advances one candidate tuple a
//   cycle. A new request waits only for the sequencer to return to idle,
//   even while a result waits.
//   The sequencer stalls in its hold state only if that result is still held.
//   Reset (i_rst_n low, synchronous): tuple to all zero, shell_count to 0,
//   result channel empty.
module orbital_index_tuple_enumerator_core
    import oite_pkg::*;
#(
    parameter int MAX_SHELLS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_step_request,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [N_W-1:0]             o_radial_first,
    output logic signed [OUT_ML_W-1:0] o_angular_first,
    output logic [N_W-1:0]             o_radial_second,
    output logic signed [OUT_ML_W-1:0] o_angular_second,
    output logic [N_W-1:0]             o_radial_third,
    output logic signed [OUT_ML_W-1:0] o_angular_third,
    output logic [N_W-1:0]             o_radial_fourth,
    output logic signed [OUT_ML_W-1:0] o_angular_fourth,
    output logic                       o_canonical,
    output logic                       o_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    // Sequencer and tuple state
    t_state                      r_state, n_state;
    t_orb                        r_orb [NUM_ORB];
    t_orb                        n_orb [NUM_ORB];
    logic [IDX_W-1:0]            r_pidx, n_pidx;
    logic [CFG_W-1:0]            r_shell_count;
    logic                        r_last, n_last;
    logic                        r_canon, n_canon;

    // Snapshot of the tuple being emitted and the pair indices
    logic [N_W-1:0]              r_snap_n  [NUM_ORB];
    logic signed [OUT_ML_W-1:0]  r_snap_ml [NUM_ORB];
    logic [P_W-1:0]              r_p       [NUM_ORB];

    // Result register
    logic                        r_o_valid, n_o_valid;
    logic [N_W-1:0]              r_o_n  [NUM_ORB];
    logic signed [OUT_ML_W-1:0]  r_o_ml [NUM_ORB];
    logic                        r_o_canon;
    logic                        r_o_last;

    logic                        w_accept;
    logic                        w_load;
    logic [CAP_W-1:0]            w_cap_req;
    logic [CAP_W-1:0]            w_cap;

    // Shared pair index unit
    t_orb                        w_sel;
    logic [KP_W-1:0]             w_abs_ml;
    logic [KP_W-1:0]             w_k;
    logic [PROD_W-1:0]           w_prod;
    logic [PROD_W-1:0]           w_psum;

    // Carry step
    t_step                       w_s0, w_s1, w_s2;
    t_orb                        w_c0, w_c1, w_c2;
    logic                        w_wrapped;
    logic signed [ML_W:0]        w_ml4;
    logic [ML_W:0]               w_mag4;

    // Canonical test
    logic [P_W-1:0]              w_lo01, w_hi01, w_lo23, w_hi23;
    logic                        w_order_ok, w_fuse_ok;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_load      = (r_state == S_HOLD) && (!r_o_valid || i_ready);

    // Shell bound: shell_count + 1, saturated at the shell limit
    assign w_cap_req = CAP_W'(r_shell_count) + CAP_W'(1);
    assign w_cap     = (w_cap_req > CAP_W'(MAX_SHELLS)) ? CAP_W'(MAX_SHELLS) : w_cap_req;

    // p = (k*(k+2) + ml) / 2, one orbital a cycle
    always_comb begin
        w_sel    = r_orb[r_pidx];
        w_abs_ml = w_sel.ml[ML_W-1] ? KP_W'(-w_sel.ml) : KP_W'(w_sel.ml);
        w_k      = KP_W'({w_sel.n, 1'b0}) + w_abs_ml;
        w_prod   = PROD_W'(w_k) * PROD_W'(w_k + KP_W'(2));
        w_psum   = w_prod + PROD_W'(signed'(w_sel.ml));
    end

    // Ripple one carry step through orbitals three, two and one
    always_comb begin
        w_s2      = orb_step(r_orb[2], w_cap);
        w_s1      = orb_step(r_orb[1], w_cap);
        w_s0      = orb_step(r_orb[0], w_cap);
        w_c2      = w_s2.orb;
        w_c1      = w_s2.wrap ? w_s1.orb : r_orb[1];
        w_c0      = (w_s2.wrap && w_s1.wrap) ? w_s0.orb : r_orb[0];
        w_wrapped = w_s2.wrap && w_s1.wrap && w_s0.wrap;
        // ml4 fixed by conservation; may exceed the stored width when out of range
        w_ml4     = (ML_W+1)'(w_c0.ml) + (ML_W+1)'(w_c1.ml) - (ML_W+1)'(w_c2.ml);
        w_mag4    = w_ml4[ML_W] ? (ML_W+1)'(-w_ml4) : (ML_W+1)'(w_ml4);
    end

    // Pair orderings
    always_comb begin
        w_lo01     = (r_p[0] < r_p[1]) ? r_p[0] : r_p[1];
        w_hi01     = (r_p[0] < r_p[1]) ? r_p[1] : r_p[0];
        w_lo23     = (r_p[2] < r_p[3]) ? r_p[2] : r_p[3];
        w_hi23     = (r_p[2] < r_p[3]) ? r_p[3] : r_p[2];
        w_order_ok = (r_p[0] < r_p[1]) || ((r_p[0] == r_p[1]) && (r_p[2] <= r_p[3]));
        w_fuse_ok  = (w_lo01 < w_lo23) || ((w_lo01 == w_lo23) && (w_hi01 <= w_hi23));
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_orb   = r_orb;
        n_pidx  = r_pidx;
        n_last  = r_last;
        n_canon = r_canon;
        unique case (r_state)
            S_IDLE: begin
                n_pidx = '0;
                if (w_accept && i_step_request) begin
                    n_state = S_PIDX;
                end
            end
            S_PIDX: begin
                n_pidx = r_pidx + IDX_W'(1);
                if (r_pidx == IDX_W'(NUM_ORB - 1)) begin
                    n_state = S_CANON;
                end
            end
            S_CANON: begin
                n_canon = w_order_ok && w_fuse_ok;
                n_state = S_ADV;
            end
            S_ADV: begin
                // step orbital four up one radial number
                n_orb[3].n = r_orb[3].n + N_W'(1);
                n_orb[3].k = r_orb[3].k + K_W'(2);
                n_state    = S_CARRY;
            end
            S_CARRY: begin
                if ({1'b0, r_orb[3].k} >= w_cap) begin
                    n_orb[0]    = w_c0;
                    n_orb[1]    = w_c1;
                    n_orb[2]    = w_c2;
                    n_orb[3].n  = '0;
                    n_orb[3].ml = w_ml4[ML_W-1:0];
                    n_orb[3].k  = w_mag4[K_W-1:0];
                    if (w_wrapped) begin
                        n_last  = 1'b1;
                        n_state = S_HOLD;
                    end
                end else begin
                    n_last  = 1'b0;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_o_valid = (r_o_valid && !i_ready) || w_load;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pidx        <= '0;
            r_shell_count <= '0;
            r_o_valid     <= 1'b0;
            for (int i = 0; i < NUM_ORB; i++) begin
                r_orb[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pidx    <= n_pidx;
            r_o_valid <= n_o_valid;
            r_orb     <= n_orb;
            if (i_cfg_valid && o_cfg_ready) begin
                r_shell_count <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_canon <= n_canon;
        if (w_accept) begin
            for (int i = 0; i < NUM_ORB; i++) begin
                r_snap_n[i]  <= r_orb[i].n;
                r_snap_ml[i] <= r_orb[i].ml[OUT_ML_W-1:0];
            end
        end
        if (r_state == S_PIDX) begin
            r_p[r_pidx] <= w_psum[P_W:1];
        end
        if (w_load) begin
            r_o_n     <= r_snap_n;
            r_o_ml    <= r_snap_ml;
            r_o_canon <= r_canon;
            r_o_last  <= r_last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_radial_first   = r_o_n[0];
    assign o_angular_first  = r_o_ml[0];
    assign o_radial_second  = r_o_n[1];
    assign o_angular_second = r_o_ml[1];
    assign o_radial_third   = r_o_n[2];
    assign o_angular_third  = r_o_ml[2];
    assign o_radial_fourth  = r_o_n[3];
    assign o_angular_fourth = r_o_ml[3];
    assign o_canonical      = r_o_canon;
    assign o_last           = r_o_last;

endmodule

[verif/orbital_index_tuple_enumerator_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the four-orbital index tuple enumerator core.
module orbital_index_tuple_enumerator_core_tb;
    import oite_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    // Quiet cycles after the last result before a register write or the verdict.
    // A stray result would show up well inside this window.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_STEPS  = 1230;
    localparam int SHELL_LIMIT   = 32;
    localparam int FUSE_SHIFT    = 16;
    // Hard stop, far beyond the slowest legal run.
    localparam int RUN_LIMIT_NS  = 50_000_000;

    // Receiver behaviour, changed after a span of random length.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATTERN,
        RX_SPARSE,
        RX_COIN
    } t_rx_mode;

    // One emitted tuple as it should appear on the result channel.
    typedef struct packed {
        logic [NUM_ORB-1:0][N_W-1:0]      radial;
        logic [NUM_ORB-1:0][OUT_ML_W-1:0] angular;
        logic                             canonical;
        logic                             last;
    } t_tuple_rec;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_ready;
    logic                       i_step_request = 1'b0;
    logic                       o_valid;
    logic                       i_ready        = 1'b0;
    logic [N_W-1:0]             o_radial_first;
    logic signed [OUT_ML_W-1:0] o_angular_first;
    logic [N_W-1:0]             o_radial_second;
    logic signed [OUT_ML_W-1:0] o_angular_second;
    logic [N_W-1:0]             o_radial_third;
    logic signed [OUT_ML_W-1:0] o_angular_third;
    logic [N_W-1:0]             o_radial_fourth;
    logic signed [OUT_ML_W-1:0] o_angular_fourth;
    logic                       o_canonical;
    logic                       o_last;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_W-1:0]           i_cfg_data     = '0;

    // Gather the orbital outputs so that index 0 is orbital one.
    logic [NUM_ORB-1:0][N_W-1:0]      got_radial;
    logic [NUM_ORB-1:0][OUT_ML_W-1:0] got_angular;

    assign got_radial  = {o_radial_fourth, o_radial_third, o_radial_second, o_radial_first};
    assign got_angular = {o_angular_fourth, o_angular_third, o_angular_second,
                          o_angular_first};

    orbital_index_tuple_enumerator_core #(
        .MAX_SHELLS(SHELL_LIMIT)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_step_request   (i_step_request),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_radial_first   (o_radial_first),
        .o_angular_first  (o_angular_first),
        .o_radial_second  (o_radial_second),
        .o_angular_second (o_angular_second),
        .o_radial_third   (o_radial_third),
        .o_angular_third  (o_angular_third),
        .o_radial_fourth  (o_radial_fourth),
        .o_angular_fourth (o_angular_fourth),
        .o_canonical      (o_canonical),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tuple predictor: its own copy of the sweep position and of shell_count.
    // Plain integers hold the state so that a candidate orbital four whose ml
    // lies far outside the range is still judged exactly before being skipped.
    // ------------------------------------------------------------------
    int               orb_n  [NUM_ORB];
    int               orb_ml [NUM_ORB];
    int               orb_k  [NUM_ORB];
    logic [CFG_W-1:0] model_shell_count = '0;

    t_tuple_rec expected_tuples[$];
    bit         step_queue[$];

    int   requests_queued = 0;
    int   requests_taken  = 0;
    int   mismatches      = 0;
    logic req_accepted    = 1'b0;

    // Driver and receiver bookkeeping.
    int       gap_left      = 0;
    int       burst_left    = 1;
    t_rx_mode stall_mode    = RX_OPEN;
    int       stall_span    = 0;
    bit [31:0] stall_pattern = '1;

    // Position of an orbital in the fixed ordering of all (n, ml) pairs.
    function automatic int unsigned pair_ordinal(int n, int ml);
        int k;
        k = 2 * n + ((ml < 0) ? -ml : ml);
        return (k * (k + 2) + ml) / 2;
    endfunction

    // Pack a pair as (smaller ordinal, larger ordinal) for a lexicographic compare.
    function automatic longint unsigned fused_pair(int unsigned a, int unsigned b);
        longint unsigned lo;
        longint unsigned hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (lo << FUSE_SHIFT) ^ hi;
    endfunction

    // Move orbital o to its next (n, ml); report a wrap back to (0, 0).
    function automatic bit step_orbital_shell(int o, int cap);
        if (orb_ml[o] > -1) begin
            if (orb_n[o] == 0) begin
                // top of the shell: open the next one at its most negative ml
                orb_ml[o] = -orb_ml[o] - 1;
                orb_k[o]  = orb_k[o] + 1;
                if (orb_k[o] >= cap) begin
                    orb_ml[o] = 0;
                    orb_k[o]  = 0;
                    return 1'b1;
                end
                return 1'b0;
            end
            orb_n[o] = orb_n[o] - 1;
        end else if (orb_ml[o] < -1) begin
            orb_n[o] = orb_n[o] + 1;
        end
        orb_ml[o] = orb_ml[o] + 2;
        return 1'b0;
    endfunction

    // Step orbital four's n, then ripple the carry while orbital four lies
    // outside the shell range. Report a wrap of the whole sweep.
    function automatic bit advance_to_next_tuple(int cap);
        bit wrapped;
        int ml4;
        orb_n[3] = orb_n[3] + 1;
        orb_k[3] = orb_k[3] + 2;
        while (orb_k[3] >= cap) begin
            wrapped = step_orbital_shell(2, cap) && step_orbital_shell(1, cap) &&
                      step_orbital_shell(0, cap);
            ml4       = orb_ml[0] + orb_ml[1] - orb_ml[2];
            orb_n[3]  = 0;
            orb_ml[3] = ml4;
            orb_k[3]  = (ml4 < 0) ? -ml4 : ml4;
            if (wrapped)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Capture the current tuple with its flags, then advance the sweep.
    function automatic t_tuple_rec emit_and_advance();
        t_tuple_rec  rec;
        int unsigned p [NUM_ORB];
        int          cap;
        for (int i = 0; i < NUM_ORB; i++) begin
            p[i]           = pair_ordinal(orb_n[i], orb_ml[i]);
            rec.radial[i]  = N_W'(orb_n[i]);
            rec.angular[i] = OUT_ML_W'(orb_ml[i]);
        end
        rec.canonical = (p[0] < p[1] || (p[0] == p[1] && p[2] <= p[3])) &&
                        fused_pair(p[0], p[1]) <= fused_pair(p[2], p[3]);
        // Shells in use: shell_count + 1, saturated at the instance limit.
        cap = int'(model_shell_count) + 1;
        if (cap > SHELL_LIMIT)
            cap = SHELL_LIMIT;
        rec.last = advance_to_next_tuple(cap);
        return rec;
    endfunction

    function automatic void compare_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge. Check the result
    // transaction first, then predict for the request taken at the same edge;
    // the block cannot return a request's result at the edge that takes it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tuple_rec want;
        if (!i_rst_n) begin
            req_accepted <= 1'b0;
        end else begin
            req_accepted <= i_valid && o_ready;
            if (i_cfg_valid && o_cfg_ready)
                model_shell_count = i_cfg_data;
            if (o_valid && i_ready) begin
                if (expected_tuples.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, actual last %0b",
                             $time, o_last);
                    mismatches++;
                end else begin
                    want = expected_tuples.pop_front();
                    for (int i = 0; i < NUM_ORB; i++) begin
                        compare_field($sformatf("radial of orbital %0d", i + 1),
                                      int'(want.radial[i]), int'(got_radial[i]));
                        compare_field($sformatf("angular of orbital %0d", i + 1),
                                      int'($signed(want.angular[i])),
                                      int'($signed(got_angular[i])));
                    end
                    compare_field("canonical", int'(want.canonical), int'(o_canonical));
                    compare_field("last", int'(want.last), int'(o_last));
                end
            end
            if (i_valid && o_ready) begin
                requests_taken <= requests_taken + 1;
                if (i_step_request)
                    expected_tuples.push_back(emit_and_advance());
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present request transactions at the falling edge, in bursts of
    // random length separated by random gaps. Hold valid and payload until
    // the transaction is taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_accepted)) begin
            if (gap_left > 0 || step_queue.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                i_valid        <= 1'b1;
                i_step_request <= step_queue.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a quarter of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, switching mode now and then.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode    <= t_rx_mode'($urandom_range(0, 3));
            stall_span    <= $urandom_range(16, 160);
            stall_pattern <= $urandom;
        end else begin
            stall_span    <= stall_span - 1;
            stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
        end
        case (stall_mode)
            RX_OPEN:    i_ready <= 1'b1;
            RX_PATTERN: i_ready <= stall_pattern[0];
            RX_SPARSE:  i_ready <= ($urandom_range(0, 11) == 0);
            default:    i_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Queue one request transaction for the driver.
    task automatic push_step(bit req);
        step_queue.push_back(req);
        requests_queued++;
    endtask

    // Queue a run of step requests, with blank requests mixed in now and then.
    task automatic load_steps(int steps, int blank_pct);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(1, 100) <= blank_pct)
                push_step(1'b0);
            push_step(1'b1);
        end
    endtask

    // Hold until every queued transaction is taken and every tuple has come back.
    task automatic drain();
        while (requests_taken != requests_queued || expected_tuples.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write shell_count once the block is idle.
    task automatic write_shell_count(logic [CFG_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int budget;
        int phase;
        int setting;
        int count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset bound: a single shell, so every request returns the all-zero
        // tuple and closes the sweep. Drop a blank request in between.
        push_step(1'b1);
        push_step(1'b1);
        push_step(1'b0);
        push_step(1'b1);

        // Two shells: step part way through a sweep, with a blank request inside.
        write_shell_count(CFG_W'(1));
        load_steps(5, 0);
        push_step(1'b0);
        load_steps(5, 0);

        // Widest bound mid-sweep, then shrink to one shell while orbitals sit
        // beyond it: they finish their shell before carrying.
        write_shell_count('1);
        load_steps(4, 0);
        write_shell_count('0);
        load_steps(4, 0);

        // Random phases: mostly small bounds so that sweeps wrap often, with
        // the extremes forced first and revisited now and then.
        budget = RANDOM_STEPS;
        phase  = 0;
        while (budget > 0) begin
            if (phase == 0) begin
                setting = 31;
            end else if (phase == 1) begin
                setting = 0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: setting = $urandom_range(1, 4);
                    6, 7:             setting = $urandom_range(5, 31);
                    default:          setting = ($urandom_range(0, 1) == 1) ? 31 : 0;
                endcase
            end
            count = $urandom_range(60, 160);
            if (count > budget)
                count = budget;
            write_shell_count(CFG_W'(setting));
            load_steps(count / 2, 10);
            // Starve the block until every tuple is back, at least once.
            if (phase == 0 || $urandom_range(0, 2) == 0)
                drain();
            load_steps(count - count / 2, 10);
            budget -= count;
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: stop a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
